// ===== rtl/column_value_match_filter_unit_defines.svh =====
// Assertion macros for the column value match filter
`ifndef COLUMN_VALUE_MATCH_FILTER_UNIT_DEFINES_SVH
`define COLUMN_VALUE_MATCH_FILTER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CVMF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert failed");
`define CVMF_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assert failed");
`else
`define CVMF_ASSERT(label, clk, rst_n, prop)
`define CVMF_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/cvmf_pkg.sv =====
// Package with types and constants of the column value match filter
package cvmf_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned RowW  = 31;
  localparam logic [31:0] NaLowWord = 32'd1954;

  typedef enum logic [1:0] {
    REG_MATCH_MODE   = 2'd0,
    REG_NEGATE       = 2'd1,
    REG_ELEMENT_KIND = 2'd2,
    REG_KEY_COUNT    = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_INT32  = 2'd0,
    KIND_INT64  = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_SPARE  = 2'd3
  } elem_kind_e;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  function automatic logic is_nan(input logic [63:0] b);
    return (&b[62:52]) && (|b[51:0]);
  endfunction

  function automatic logic is_na(input logic [63:0] b);
    return is_nan(b) && (b[31:0] == NaLowWord);
  endfunction

  // raw equality under the given element kind
  function automatic logic plain_eq(input logic [1:0] kind, input logic [63:0] e,
                                    input logic [63:0] k);
    logic r;
    r = 1'b0;
    case (kind)
      KIND_INT32:  r = (e[31:0] == k[31:0]);
      KIND_DOUBLE: r = !is_nan(e) && !is_nan(k) &&
                       ((e == k) || ((e[62:0] == '0) && (k[62:0] == '0)));
      default:     r = (e == k);
    endcase
    return r;
  endfunction
endpackage

// ===== rtl/column_value_match_filter_unit.sv =====
// Column value match filter: four-stage pipeline with a key table
// A test item's result is registered through stages 1 to 4 before it is presented; a stall holds it.
// Throughput: one item per cycle while the output is not stalled.
// Key loads give no result and only write the key register file.
// Reset (rst_ni low, async) clears valid bits and config registers.
// Key entries stay undefined until loaded.
`include "column_value_match_filter_unit_defines.svh"
module column_value_match_filter_unit #(
  parameter int unsigned KEY_SLOTS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: key_slot[3:0], data_word[67:4], row_index[98:68], zero fill [103:99]
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tlast,   // column_end
  input  logic         s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: hit[0], hit_index[31:1]
  output logic [31:0]  m_axis_tdata,
  output logic         m_axis_tlast,   // scan_done
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [4:0]   cfg_data_i
);
  localparam int unsigned CntW = $clog2(KEY_SLOTS + 1);
  localparam int unsigned SlotW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  typedef struct packed {
    logic [cvmf_pkg::DataW-1:0]  word;
    logic [cvmf_pkg::RowW-1:0]   row;
    logic                        last;
  } item_t;

  // config registers
  logic       mode_q, neg_q;
  logic [1:0] kind_q;
  logic [4:0] kcnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; neg_q <= 1'b0; kind_q <= '0; kcnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cvmf_pkg::REG_MATCH_MODE:   mode_q <= cfg_data_i[0];
        cvmf_pkg::REG_NEGATE:       neg_q  <= cfg_data_i[0];
        cvmf_pkg::REG_ELEMENT_KIND: kind_q <= cfg_data_i[1:0];
        cvmf_pkg::REG_KEY_COUNT:    kcnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // key count saturated to table size
  logic [CntW-1:0] nkeys;
  always_comb begin
    if (32'(kcnt_q) > KEY_SLOTS) nkeys = CntW'(KEY_SLOTS);
    else nkeys = CntW'(kcnt_q);
  end

  // global stall: whole pipe advances when output free
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // stage 1: capture item, load keys
  logic  v1_q;
  item_t it1_q;
  logic [cvmf_pkg::DataW-1:0] keys_q [KEY_SLOTS];
  logic [3:0] slot_in;
  assign slot_in = s_axis_tdata[3:0];

  always_ff @(posedge clk_i) begin
    if (acc && (s_axis_tuser == cvmf_pkg::REQ_LOAD) && (32'(slot_in) < KEY_SLOTS))
      keys_q[SlotW'(slot_in)] <= s_axis_tdata[67:4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= acc && (s_axis_tuser == cvmf_pkg::REQ_TEST);
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q.word <= s_axis_tdata[67:4];
      it1_q.row  <= s_axis_tdata[98:68];
      it1_q.last <= s_axis_tlast;
    end
  end

  // stage 2: per-key compares
  logic  v2_q;
  item_t it2_q;
  logic [KEY_SLOTS-1:0] eq2_q;
  logic eq0_2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      it2_q <= it1_q;
      for (int j = 0; j < KEY_SLOTS; j++)
        eq2_q[j] <= cvmf_pkg::plain_eq(kind_q, it1_q.word, keys_q[j]) &&
                    (CntW'(j) < nkeys);
      // equality mode decision with NaN rules
      if (kind_q == cvmf_pkg::KIND_DOUBLE && cvmf_pkg::is_na(keys_q[0]))
        eq0_2_q <= cvmf_pkg::is_nan(it1_q.word);
      else if (kind_q == cvmf_pkg::KIND_DOUBLE && cvmf_pkg::is_nan(keys_q[0]))
        eq0_2_q <= cvmf_pkg::is_nan(it1_q.word) && !cvmf_pkg::is_na(it1_q.word);
      else
        eq0_2_q <= cvmf_pkg::plain_eq(kind_q, it1_q.word, keys_q[0]);
    end
  end

  // stage 3: reduce and select mode
  logic  v3_q, hit3_q;
  item_t it3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      it3_q  <= it2_q;
      hit3_q <= (mode_q ? (|eq2_q) : eq0_2_q) ^ neg_q;
    end
  end

  // stage 4: output register
  logic                      v4_q, hit4_q, last4_q;
  logic [cvmf_pkg::RowW-1:0] row4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit4_q  <= hit3_q;
      row4_q  <= it3_q.row;
      last4_q <= it3_q.last;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {row4_q, hit4_q};
  assign m_axis_tlast  = last4_q;

  `CVMF_ASSERT(a_tready_follows_out, clk_i, rst_ni,
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `CVMF_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
  `CVMF_ASSERT_NEXT(a_load_no_result, clk_i, rst_ni, adv && !(acc && s_axis_tuser),
    !v1_q)
endmodule
